/* src/gjpf_pkg.sv */
// shared types, widths and codes for the grid jump point finder
// no dependencies; imported by every module of the block
package gjpf_pkg;

    localparam int ROW_W      = 8;
    localparam int COL_W      = 8;
    localparam int MAX_ROWS   = 1 << ROW_W;
    localparam int MAX_COLS   = 1 << COL_W;
    localparam int SIZE_W     = ROW_W + 1;
    localparam int ADDR_W     = ROW_W + COL_W;
    localparam int POS_W      = ROW_W + 2;
    localparam int DATA_W     = 24;
    localparam int M_DATA_W   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_JUMP  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GOAL_ROW   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GOAL_COL   = 2'd3;

    localparam logic [2:0] DIR_UP        = 3'd0;
    localparam logic [2:0] DIR_DOWN      = 3'd1;
    localparam logic [2:0] DIR_LEFT      = 3'd2;
    localparam logic [2:0] DIR_RIGHT     = 3'd3;
    localparam logic [2:0] DIR_UPLEFT    = 3'd4;
    localparam logic [2:0] DIR_DOWNLEFT  = 3'd5;
    localparam logic [2:0] DIR_UPRIGHT   = 3'd6;
    localparam logic [2:0] DIR_DOWNRIGHT = 3'd7;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [2:0]       dir;
    } query_t;

    typedef struct packed {
        logic             found;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } result_t;

    typedef struct packed {
        logic [SIZE_W-1:0] eff_h;
        logic [SIZE_W-1:0] eff_w;
        logic [ROW_W-1:0]  goal_row;
        logic [COL_W-1:0]  goal_col;
    } map_cfg_t;

    function automatic logic signed [1:0] dir_dr(input logic [2:0] d);
        logic signed [1:0] v;
        case (d)
            DIR_UP, DIR_UPLEFT, DIR_UPRIGHT:         v = -2'sd1;
            DIR_DOWN, DIR_DOWNLEFT, DIR_DOWNRIGHT:   v = 2'sd1;
            default:                                 v = 2'sd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [1:0] dir_dc(input logic [2:0] d);
        logic signed [1:0] v;
        case (d)
            DIR_LEFT, DIR_UPLEFT, DIR_DOWNLEFT:      v = -2'sd1;
            DIR_RIGHT, DIR_UPRIGHT, DIR_DOWNRIGHT:   v = 2'sd1;
            default:                                 v = 2'sd0;
        endcase
        return v;
    endfunction

endpackage

/* src/grid_jump_point_finder_core.sv */
// top level of the grid jump point finder: stream ports, config registers
// depends on gjpf_pkg, gjpf_grid and gjpf_walk
//
//  channel  dir  handshake            contents
//  s_       in   s_tvalid/s_tready    cell write or jump query
//  m_       out  m_tvalid/m_tready    one result per jump query
//  cfg_     in   cfg_valid/cfg_ready  map size and goal registers
//
// a cell write is stored as it is accepted; a jump query walks each visited cell through
// one step, five reads of the single grid read port, a drain and an evaluation,
// diagonal queries adding the side walks from every diagonal cell
// after reset all 65536 grid cells are swept clear, s_tready low meanwhile
// s_tready stays low while a query runs and until its result is taken
module grid_jump_point_finder_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [gjpf_pkg::DATA_W-1:0]     s_tdata,   // start_row, start_col, cell_blocked, direction
    input  logic                            s_tuser,   // command
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [gjpf_pkg::M_DATA_W-1:0]   m_tdata,   // jump_row, jump_col
    output logic                            m_tuser,   // found
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [gjpf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gjpf_pkg::CFG_DATA_W-1:0] cfg_data
);
    import gjpf_pkg::*;

    logic [SIZE_W-1:0] map_height_reg, map_width_reg;
    logic [ROW_W-1:0]  goal_row_reg;
    logic [COL_W-1:0]  goal_col_reg;
    map_cfg_t          cfg;
    query_t            query;
    result_t           result;
    logic              s_accept, clearing, walk_busy, rd_data;
    logic [ADDR_W-1:0] rd_addr;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_height_reg <= SIZE_W'(MAX_ROWS);
            map_width_reg  <= SIZE_W'(MAX_COLS);
            goal_row_reg   <= '0;
            goal_col_reg   <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_MAP_HEIGHT: map_height_reg <= cfg_data[SIZE_W-1:0];
                CFG_MAP_WIDTH:  map_width_reg  <= cfg_data[SIZE_W-1:0];
                CFG_GOAL_ROW:   goal_row_reg   <= cfg_data[ROW_W-1:0];
                CFG_GOAL_COL:   goal_col_reg   <= cfg_data[COL_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    assign cfg.eff_h    = (map_height_reg > SIZE_W'(MAX_ROWS)) ? SIZE_W'(MAX_ROWS)
                                                               : map_height_reg;
    assign cfg.eff_w    = (map_width_reg > SIZE_W'(MAX_COLS)) ? SIZE_W'(MAX_COLS)
                                                              : map_width_reg;
    assign cfg.goal_row = goal_row_reg;
    assign cfg.goal_col = goal_col_reg;

    assign query.row = s_tdata[ROW_W-1:0];
    assign query.col = s_tdata[ROW_W+COL_W-1:ROW_W];
    assign query.dir = s_tdata[ADDR_W+3:ADDR_W+1];

    assign s_tready = !clearing && !walk_busy;
    assign s_accept = s_tvalid && s_tready;

    gjpf_grid u_grid (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (s_accept && (s_tuser == CMD_WRITE)),
        .wr_addr  ({query.row, query.col}),
        .wr_data  (s_tdata[ADDR_W]),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .clearing (clearing)
    );

    gjpf_walk u_walk (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (s_accept && (s_tuser == CMD_JUMP)),
        .query     (query),
        .cfg       (cfg),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .busy      (walk_busy),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .result    (result)
    );

    assign m_tdata = {result.col, result.row};
    assign m_tuser = result.found;

endmodule

/* src/gjpf_grid.sv */
// one-bit occupancy memory with a clearing sweep after reset
// depends on gjpf_pkg
module gjpf_grid (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   wr_en,
    input  logic [gjpf_pkg::ADDR_W-1:0] wr_addr,
    input  logic                   wr_data,
    input  logic [gjpf_pkg::ADDR_W-1:0] rd_addr,
    output logic                   rd_data,
    output logic                   clearing
);
    import gjpf_pkg::*;

    logic              mem [MAX_ROWS*MAX_COLS];
    logic              clearing_reg;
    logic [ADDR_W-1:0] clr_addr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clearing_reg) begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == {ADDR_W{1'b1}}) begin
                clearing_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (clearing_reg) begin
            mem[clr_addr_reg] <= 1'b0;
        end else if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

    assign clearing = clearing_reg;

endmodule

/* src/gjpf_walk.sv */
// walk sequencer: steps, neighbourhood reads and the shared step evaluator
// depends on gjpf_pkg; reads the grid through gjpf_grid
module gjpf_walk (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  gjpf_pkg::query_t            query,
    input  gjpf_pkg::map_cfg_t          cfg,
    output logic [gjpf_pkg::ADDR_W-1:0] rd_addr,
    input  logic                        rd_data,
    output logic                        busy,
    output logic                        res_valid,
    input  logic                        res_ready,
    output gjpf_pkg::result_t           result
);
    import gjpf_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_STEP = 3'd1;
    localparam logic [2:0] ST_RD   = 3'd2;
    localparam logic [2:0] ST_WAIT = 3'd3;
    localparam logic [2:0] ST_EVAL = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    localparam logic [1:0] SUB_MAIN = 2'd0;
    localparam logic [1:0] SUB_HORZ = 2'd1;
    localparam logic [1:0] SUB_VERT = 2'd2;

    localparam logic [2:0] LAST_IDX = 3'd4;

    logic [2:0]              state_reg, state_next;
    logic [1:0]              sub_reg, sub_next;
    logic signed [POS_W-1:0] pos_r_reg, pos_r_next, pos_c_reg, pos_c_next;
    logic signed [POS_W-1:0] base_r_reg, base_r_next, base_c_reg, base_c_next;
    logic signed [1:0]       dr_reg, dr_next, dc_reg, dc_next;
    logic signed [1:0]       ddr_reg, ddr_next, ddc_reg, ddc_next;
    logic                    diag_reg, diag_next;
    logic [2:0]              idx_reg, idx_next;
    logic [2:0]              pidx_reg;
    logic                    pend_reg;
    logic                    inmap_q_reg;
    logic [4:0]              blk_reg, fre_reg;
    result_t                 res_reg, res_next;

    logic signed [2:0]       off_r, off_c, pr, pc, dr3, dc3;
    logic                    straight;
    logic signed [POS_W-1:0] nr, nc;
    logic                    n_inmap;
    logic                    at_goal, forced, hit, miss;

    function automatic logic in_map(input logic signed [POS_W-1:0] r,
                                    input logic signed [POS_W-1:0] c,
                                    input logic [SIZE_W-1:0] h,
                                    input logic [SIZE_W-1:0] w);
        return !r[POS_W-1] && (r[SIZE_W-1:0] < h) && !c[POS_W-1] && (c[SIZE_W-1:0] < w);
    endfunction

    // neighbourhood offsets: centre, then the two side pairs of the pruning rule
    always_comb begin
        dr3      = 3'(dr_reg);
        dc3      = 3'(dc_reg);
        pr       = dc3;
        pc       = dr3;
        straight = (dr_reg == 2'sd0) || (dc_reg == 2'sd0);
        off_r    = 3'sd0;
        off_c    = 3'sd0;
        case (idx_reg)
            3'd1: begin
                off_r = straight ? dr3 + pr : -dr3;
                off_c = straight ? dc3 + pc : dc3;
            end
            3'd2: begin
                off_r = straight ? pr : -dr3;
                off_c = straight ? pc : 3'sd0;
            end
            3'd3: begin
                off_r = straight ? dr3 - pr : dr3;
                off_c = straight ? dc3 - pc : -dc3;
            end
            3'd4: begin
                off_r = straight ? -pr : 3'sd0;
                off_c = straight ? -pc : -dc3;
            end
            default: begin
                off_r = 3'sd0;
                off_c = 3'sd0;
            end
        endcase
        nr      = pos_r_reg + POS_W'(off_r);
        nc      = pos_c_reg + POS_W'(off_c);
        n_inmap = in_map(nr, nc, cfg.eff_h, cfg.eff_w);
        rd_addr = {nr[ROW_W-1:0], nc[COL_W-1:0]};
    end

    assign at_goal = (pos_r_reg == POS_W'({1'b0, cfg.goal_row}))
                  && (pos_c_reg == POS_W'({1'b0, cfg.goal_col}));
    assign forced  = (fre_reg[1] && blk_reg[2]) || (fre_reg[3] && blk_reg[4]);
    assign hit     = at_goal || (fre_reg[0] && forced);
    assign miss    = !at_goal && !fre_reg[0];

    always_comb begin
        state_next  = state_reg;
        sub_next    = sub_reg;
        pos_r_next  = pos_r_reg;
        pos_c_next  = pos_c_reg;
        base_r_next = base_r_reg;
        base_c_next = base_c_reg;
        dr_next     = dr_reg;
        dc_next     = dc_reg;
        ddr_next    = ddr_reg;
        ddc_next    = ddc_reg;
        diag_next   = diag_reg;
        idx_next    = idx_reg;
        res_next    = res_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    pos_r_next = POS_W'({1'b0, query.row});
                    pos_c_next = POS_W'({1'b0, query.col});
                    dr_next    = dir_dr(query.dir);
                    dc_next    = dir_dc(query.dir);
                    ddr_next   = dir_dr(query.dir);
                    ddc_next   = dir_dc(query.dir);
                    diag_next  = query.dir[2];
                    sub_next   = SUB_MAIN;
                    state_next = ST_STEP;
                end
            end
            ST_STEP: begin
                pos_r_next = pos_r_reg + POS_W'(dr_reg);
                pos_c_next = pos_c_reg + POS_W'(dc_reg);
                idx_next   = '0;
                state_next = ST_RD;
            end
            ST_RD: begin
                if (idx_reg == LAST_IDX) begin
                    state_next = ST_WAIT;
                end else begin
                    idx_next = idx_reg + 3'd1;
                end
            end
            ST_WAIT: begin
                state_next = ST_EVAL;
            end
            ST_EVAL: begin
                state_next = ST_STEP;
                unique case (sub_reg)
                    SUB_MAIN: begin
                        if (hit) begin
                            res_next   = '{found: 1'b1, row: pos_r_reg[ROW_W-1:0],
                                           col: pos_c_reg[COL_W-1:0]};
                            state_next = ST_OUT;
                        end else if (miss) begin
                            res_next   = '0;
                            state_next = ST_OUT;
                        end else if (diag_reg) begin
                            base_r_next = pos_r_reg;
                            base_c_next = pos_c_reg;
                            dr_next     = 2'sd0;
                            dc_next     = ddc_reg;
                            sub_next    = SUB_HORZ;
                        end
                    end
                    SUB_HORZ, SUB_VERT: begin
                        if (hit) begin
                            res_next   = '{found: 1'b1, row: base_r_reg[ROW_W-1:0],
                                           col: base_c_reg[COL_W-1:0]};
                            state_next = ST_OUT;
                        end else if (miss) begin
                            pos_r_next = base_r_reg;
                            pos_c_next = base_c_reg;
                            if (sub_reg == SUB_HORZ) begin
                                dr_next  = ddr_reg;
                                dc_next  = 2'sd0;
                                sub_next = SUB_VERT;
                            end else begin
                                dr_next  = ddr_reg;
                                dc_next  = ddc_reg;
                                sub_next = SUB_MAIN;
                            end
                        end
                    end
                    default: begin
                        sub_next = SUB_MAIN;
                    end
                endcase
            end
            ST_OUT: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            sub_reg   <= SUB_MAIN;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            sub_reg   <= sub_next;
            pend_reg  <= (state_reg == ST_RD);
        end
    end

    always_ff @(posedge aclk) begin
        pos_r_reg   <= pos_r_next;
        pos_c_reg   <= pos_c_next;
        base_r_reg  <= base_r_next;
        base_c_reg  <= base_c_next;
        dr_reg      <= dr_next;
        dc_reg      <= dc_next;
        ddr_reg     <= ddr_next;
        ddc_reg     <= ddc_next;
        diag_reg    <= diag_next;
        idx_reg     <= idx_next;
        res_reg     <= res_next;
        pidx_reg    <= idx_reg;
        inmap_q_reg <= n_inmap;
        // out-of-map cells are neither blocked nor free
        if (pend_reg) begin
            blk_reg[pidx_reg] <= inmap_q_reg && rd_data;
            fre_reg[pidx_reg] <= inmap_q_reg && !rd_data;
        end
    end

    assign busy      = (state_reg != ST_IDLE);
    assign res_valid = (state_reg == ST_OUT);
    assign result    = res_reg;

    a_null_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && !res_reg.found) |-> (res_reg.row == '0 && res_reg.col == '0))
        else $error("null result carries a position");
    a_wait_eval: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WAIT) |=> (state_reg == ST_EVAL))
        else $error("read drain not followed by evaluation");
    a_sub_diag: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy && sub_reg != SUB_MAIN) |-> diag_reg)
        else $error("side walk outside a diagonal query");
    a_side_straight: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EVAL && sub_reg != SUB_MAIN) |-> (dr_reg == 2'sd0 || dc_reg == 2'sd0))
        else $error("side walk not straight");

endmodule

/* dv/tb_grid_jump_point_finder_core.sv */
// self-checking testbench for grid_jump_point_finder_core: cell writes and jump queries
// are predicted in-bench from a model of the occupancy grid and checked per result item
// depends on gjpf_pkg and the grid_jump_point_finder_core rtl
module tb_grid_jump_point_finder_core;
    import gjpf_pkg::*;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [DATA_W-1:0]     s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tuser;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    grid_jump_point_finder_core i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // grid and register copy
    bit          occ_map [MAX_ROWS*MAX_COLS];
    int          map_rows;
    int          map_cols;
    int          goal_r;
    int          goal_c;
    result_t     results_due[$];

    int          errors;
    int          n_writes;
    int          n_queries;
    int          n_found;
    int          n_results;
    bit          no_idle;
    bit          hold_req;
    int          hold_left;
    int          pause_left;
    int          rdy_roll;

    initial begin
        aclk = 1'b0;
    end

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic bit in_map(int r, int c);
        int h;
        int w;
        h = (map_rows > MAX_ROWS) ? MAX_ROWS : map_rows;
        w = (map_cols > MAX_COLS) ? MAX_COLS : map_cols;
        return r >= 0 && r < h && c >= 0 && c < w;
    endfunction

    function automatic bit cell_blocked(int r, int c);
        return in_map(r, c) && occ_map[r*MAX_COLS + c];
    endfunction

    function automatic bit cell_free(int r, int c);
        return in_map(r, c) && !occ_map[r*MAX_COLS + c];
    endfunction

    function automatic bit forced_here(int r, int c, int dr, int dc);
        if (dr == 0 || dc == 0) begin
            if (cell_free(r + dr + dc, c + dc + dr) && cell_blocked(r + dc, c + dr))
                return 1'b1;
            if (cell_free(r + dr - dc, c + dc - dr) && cell_blocked(r - dc, c - dr))
                return 1'b1;
            return 1'b0;
        end
        if (cell_free(r - dr, c + dc) && cell_blocked(r - dr, c))
            return 1'b1;
        if (cell_free(r + dr, c - dc) && cell_blocked(r, c - dc))
            return 1'b1;
        return 1'b0;
    endfunction

    // 1 point here, 0 dead end, -1 keep walking
    function automatic int step_verdict(int r, int c, int dr, int dc);
        if (r == goal_r && c == goal_c)
            return 1;
        if (!in_map(r, c) || cell_blocked(r, c))
            return 0;
        if (forced_here(r, c, dr, dc))
            return 1;
        return -1;
    endfunction

    function automatic bit walk_line(int r, int c, int dr, int dc,
                                     output int orow, output int ocol);
        int k;
        forever begin
            r += dr;
            c += dc;
            k = step_verdict(r, c, dr, dc);
            if (k >= 0) begin
                orow = r;
                ocol = c;
                return k == 1;
            end
        end
    endfunction

    function automatic bit walk_diagonal(int r, int c, int dr, int dc,
                                         output int orow, output int ocol);
        int k;
        int tr;
        int tc;
        forever begin
            r += dr;
            c += dc;
            k = step_verdict(r, c, dr, dc);
            if (k >= 0) begin
                orow = r;
                ocol = c;
                return k == 1;
            end
            if (walk_line(r, c, 0, dc, tr, tc) || walk_line(r, c, dr, 0, tr, tc)) begin
                orow = r;
                ocol = c;
                return 1'b1;
            end
        end
    endfunction

    function automatic result_t jump_point(int r, int c, logic [2:0] dir);
        result_t res;
        int      jr;
        int      jc;
        bit      ok;
        if (dir < DIR_UPLEFT)
            ok = walk_line(r, c, dir_dr(dir), dir_dc(dir), jr, jc);
        else
            ok = walk_diagonal(r, c, dir_dr(dir), dir_dc(dir), jr, jc);
        res.found = ok;
        res.row   = ok ? jr[7:0] : '0;
        res.col   = ok ? jc[7:0] : '0;
        return res;
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_item(logic cmd, int row, int col, logic blk, logic [2:0] dir);
        int gap;
        @(negedge aclk);
        gap = gap_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {4'b0, dir, blk, col[7:0], row[7:0]};
        do @(posedge aclk); while (!s_tready);
        if (cmd == CMD_WRITE) begin
            occ_map[row[7:0]*MAX_COLS + col[7:0]] = blk;
            n_writes++;
        end else begin
            results_due.insert(results_due.size(), jump_point(row[7:0], col[7:0], dir));
            n_queries++;
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_W-1:0];
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_MAP_HEIGHT: map_rows = value & 9'h1FF;
            CFG_MAP_WIDTH:  map_cols = value & 9'h1FF;
            CFG_GOAL_ROW:   goal_r   = value & 8'hFF;
            CFG_GOAL_COL:   goal_c   = value & 8'hFF;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        wait (results_due.size() == 0);
        repeat (16) @(posedge aclk);
    endtask

    task automatic set_map(int h, int w, int gr, int gc);
        drain();
        write_reg(CFG_MAP_HEIGHT, h);
        write_reg(CFG_MAP_WIDTH, w);
        write_reg(CFG_GOAL_ROW, gr);
        write_reg(CFG_GOAL_COL, gc);
    endtask

    task automatic test_reset_defaults();
        send_item(CMD_JUMP, 5, 0, 1'b0, DIR_UP);
        send_item(CMD_JUMP, 0, 0, 1'b0, DIR_LEFT);
        send_item(CMD_JUMP, 0, 0, 1'b1, DIR_RIGHT);
        send_item(CMD_JUMP, 0, 0, 1'b0, DIR_UPLEFT);
        send_item(CMD_WRITE, 255, 255, 1'b1, DIR_DOWNRIGHT);
        send_item(CMD_JUMP, 255, 255, 1'b0, DIR_DOWNRIGHT);
        send_item(CMD_JUMP, 250, 255, 1'b0, DIR_DOWN);
        send_item(CMD_JUMP, 255, 200, 1'b0, DIR_DOWNLEFT);
        send_item(CMD_WRITE, 255, 255, 1'b0, DIR_UP);
    endtask

    task automatic test_map_extremes();
        logic [2:0] d;
        set_map(1, 1, 255, 255);
        for (int i = 0; i < 8; i++) begin
            d = 3'(i);
            send_item(CMD_JUMP, 0, 0, 1'b0, d);
        end
        // empty map, goal outside it still reported
        set_map(0, 0, 0, 1);
        send_item(CMD_JUMP, 0, 0, 1'b0, DIR_RIGHT);
        send_item(CMD_JUMP, 3, 3, 1'b0, DIR_DOWN);
        // oversize registers clamp to full grid
        set_map(511, 300, 100, 256 + 7);
        send_item(CMD_JUMP, 100, 0, 1'b0, DIR_RIGHT);
        send_item(CMD_WRITE, 101, 40, 1'b1, DIR_UP);
        send_item(CMD_JUMP, 150, 0, 1'b0, DIR_RIGHT);
        send_item(CMD_JUMP, 100, 39, 1'b0, DIR_LEFT);
        send_item(CMD_JUMP, 0, 9, 1'b0, DIR_UPRIGHT);
        send_item(CMD_WRITE, 101, 40, 1'b0, DIR_UP);
    endtask

    task automatic test_forced_neighbours();
        set_map(8, 8, 200, 200);
        send_item(CMD_WRITE, 3, 4, 1'b1, DIR_UP);
        send_item(CMD_JUMP, 2, 0, 1'b0, DIR_RIGHT);
        send_item(CMD_JUMP, 7, 4, 1'b0, DIR_UP);
        send_item(CMD_JUMP, 0, 0, 1'b0, DIR_DOWNRIGHT);
        send_item(CMD_JUMP, 3, 4, 1'b0, DIR_DOWNLEFT);
        send_item(CMD_WRITE, 3, 4, 1'b0, DIR_UP);
    endtask

    // small maps keep nested diagonal walks short
    task automatic test_random_small(int n_items);
        int h;
        int w;
        int r;
        int c;
        h = $urandom_range(2, 12);
        w = $urandom_range(2, 12);
        if ($urandom_range(0, 1))
            set_map(h, w, $urandom_range(0, h - 1), $urandom_range(0, w - 1));
        else
            set_map(h, w, $urandom_range(0, 511), $urandom_range(0, 511));
        for (int i = 0; i < n_items; i++) begin
            if ($urandom_range(0, 9) < 2) begin
                r = $urandom_range(0, 255);
                c = $urandom_range(0, 255);
            end else begin
                r = $urandom_range(0, h);
                c = $urandom_range(0, w);
            end
            if ($urandom_range(0, 9) < 4)
                send_item(CMD_WRITE, r, c, $urandom_range(0, 9) < 3, 3'($urandom_range(0, 7)));
            else
                send_item(CMD_JUMP, r, c, 1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)));
        end
    endtask

    // full grid: straight walks only, diagonals only from an outward edge
    task automatic test_random_full(int n_items);
        int r;
        int c;
        set_map(256, 256, $urandom_range(0, 255), $urandom_range(0, 255));
        for (int i = 0; i < n_items; i++) begin
            r = $urandom_range(0, 255);
            c = $urandom_range(0, 255);
            case ($urandom_range(0, 3))
                0: send_item(CMD_WRITE, r, c, 1'($urandom_range(0, 1)),
                             3'($urandom_range(0, 7)));
                1: send_item(CMD_JUMP, r, c, 1'b0, 3'($urandom_range(0, 3)));
                2: send_item(CMD_JUMP, 0, c, 1'b1, $urandom_range(0, 1) ? DIR_UPLEFT : DIR_UPRIGHT);
                default: send_item(CMD_JUMP, 255, c, 1'b0,
                                   $urandom_range(0, 1) ? DIR_DOWNLEFT : DIR_DOWNRIGHT);
            endcase
        end
    endtask

    task automatic test_output_hold();
        set_map(6, 6, 5, 5);
        hold_req = 1'b1;
        for (int i = 0; i < 10; i++)
            send_item(CMD_JUMP, $urandom_range(0, 5), $urandom_range(0, 5), 1'b0,
                      3'($urandom_range(0, 7)));
    endtask

    always @(negedge aclk) begin
        if (hold_req) begin
            hold_left = 400;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (pause_left > 0) begin
            pause_left--;
            m_tready <= 1'b0;
        end else begin
            rdy_roll = $urandom_range(0, 99);
            if (!no_idle && rdy_roll < 5)
                pause_left = $urandom_range(10, 50);
            m_tready <= no_idle || rdy_roll >= 35;
        end
    end

    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            n_results++;
            if (results_due.size() == 0) begin
                $display("%0t: unexpected result item found=%0b row=%0d col=%0d",
                         $time, m_tuser, m_tdata[7:0], m_tdata[15:8]);
                errors++;
            end else begin
                want = results_due.pop_front();
                if (want.found) n_found++;
                if (m_tuser !== want.found) begin
                    $display("%0t: found expected %0b actual %0b", $time, want.found, m_tuser);
                    errors++;
                end
                if (m_tdata[7:0] !== want.row) begin
                    $display("%0t: jump_row expected %0d actual %0d",
                             $time, want.row, m_tdata[7:0]);
                    errors++;
                end
                if (m_tdata[15:8] !== want.col) begin
                    $display("%0t: jump_col expected %0d actual %0d",
                             $time, want.col, m_tdata[15:8]);
                    errors++;
                end
            end
        end
    end

    initial begin
        #1_000_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = 1'b0;
        m_tready   = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        map_rows   = 256;
        map_cols   = 256;
        goal_r     = 0;
        goal_c     = 0;
        errors     = 0;
        n_writes   = 0;
        n_queries  = 0;
        n_found    = 0;
        n_results  = 0;
        no_idle    = 1'b0;
        hold_req   = 1'b0;
        hold_left  = 0;
        pause_left = 0;
        aresetn    = 1'b0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        test_map_extremes();
        test_forced_neighbours();
        test_output_hold();
        for (int p = 0; p < 12; p++) begin
            no_idle = (p % 4 == 3);
            test_random_small(105);
        end
        no_idle = 1'b0;
        test_random_full(60);
        test_random_small(60);

        drain();
        $display("covered %0d cell writes and %0d jump queries, %0d results with %0d points found",
                 n_writes, n_queries, n_results, n_found);
        $display("map sizes from empty to clamped full grid, goals in and out of the map");
        if (errors == 0 && results_due.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
